// ===== rtl/two_dim_dominance_counter_unit_assert.svh =====
// Assertion macros used by the checker file of the dominance counter.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef TWO_DIM_DOMINANCE_COUNTER_UNIT_ASSERT_SVH
`define TWO_DIM_DOMINANCE_COUNTER_UNIT_ASSERT_SVH

// checked only while out of reset
`define DDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ddc_pkg.sv =====
// Shared constants and types of the dominance counter.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none
package ddc_pkg;
  localparam int GRID_SIDE   = 64;
  localparam int COUNT_WIDTH = 20;
  localparam int COORD_W     = 7;
  localparam int OUT_W       = 20;
  localparam int IDX_W       = $clog2(GRID_SIDE);
  localparam int WALK_W      = IDX_W + 2;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int DEPTH       = 2 ** ADDR_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      addr;
    logic [COUNT_WIDTH-1:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/two_dim_dominance_counter_unit.sv =====
// Two-dimensional dominance counter: top level.
// Input words carry an opcode and a point (coord_b, coord_c). An insert
// adds one point to a 64 x 64 grid of saturating prefix counts; a query
// returns on the output channel how many stored points have both
// coordinates at or below the queried pair. Inserts give no output word.
// Coordinates are clamped to the side held in range_in_use (written via
// cfg_we/cfg_wdata, by the user only while idle, which the block does not
// enforce; reset value 64); insert coordinates of zero become one, and a
// query coordinate of zero answers zero. After rst the store is cleared one
// entry per cycle, all 4096 entries, before in_ready first rises.
// One word is worked at a time. The walk visits up to 7 x 7 store entries
// at the default grid, each a read and an add/write on the single store
// port, through states S_READ and S_ACC; a query then passes S_DONE to
// reach the output register. A zero query goes straight to S_DONE.
// The result sits in an output register; while it is full and out_ready is
// low, a finished query waits in the sequencer and no new word is taken.
// Depends on ddc_pkg, ddc_seq, ddc_alu and ddc_store.
`default_nettype none
module two_dim_dominance_counter_unit import ddc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [COORD_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               opcode,
  input  wire logic [COORD_W-1:0] coord_b,
  input  wire logic [COORD_W-1:0] coord_c,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [OUT_W-1:0]        dominated_count
);
  logic [COORD_W-1:0]     range_in_use;
  logic                   result_load;
  logic [COUNT_WIDTH-1:0] result;
  logic [COUNT_WIDTH-1:0] rdata;
  mem_req_t               req;

  ddc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .range_in_use (range_in_use),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .coord_b      (coord_b),
    .coord_c      (coord_c),
    .out_free     (!out_valid || out_ready),
    .result_load  (result_load),
    .result       (result),
    .req          (req),
    .rdata        (rdata)
  );

  ddc_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_in_use <= COORD_W'(GRID_SIDE);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) range_in_use <= cfg_wdata;
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (result_load) dominated_count <= OUT_W'(result);
  end
endmodule
`default_nettype wire

// ===== rtl/ddc_store.sv =====
// Prefix-count store: one write and one registered read per cycle.
// Depends on ddc_pkg.
`default_nettype none
module ddc_store import ddc_pkg::*; (
  input  wire logic                   clk,
  input  wire mem_req_t               req,
  output logic [COUNT_WIDTH-1:0]      rdata
);
  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

// ===== rtl/ddc_alu.sv =====
// Shared saturating adder for store increments and query sums.
// Depends on ddc_pkg.
`default_nettype none
module ddc_alu import ddc_pkg::*; (
  input  wire logic [COUNT_WIDTH-1:0] entry,
  input  wire logic [COUNT_WIDTH-1:0] addend,
  output logic [COUNT_WIDTH-1:0]      result
);
  logic [COUNT_WIDTH:0] total;

  always_comb begin
    total = {1'b0, entry} + {1'b0, addend};
    if (total[COUNT_WIDTH]) begin
      result = '1;
    end else begin
      result = total[COUNT_WIDTH-1:0];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ddc_seq.sv =====
// Sequencer: store clear after reset, coordinate clamping and the
// two-level tree walk. Depends on ddc_pkg, drives ddc_store and ddc_alu.
`default_nettype none
module ddc_seq import ddc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [COORD_W-1:0]     range_in_use,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   opcode,
  input  wire logic [COORD_W-1:0]     coord_b,
  input  wire logic [COORD_W-1:0]     coord_c,
  input  wire logic                   out_free,
  output logic                        result_load,
  output logic [COUNT_WIDTH-1:0]      result,
  output mem_req_t                    req,
  input  wire logic [COUNT_WIDTH-1:0] rdata
);
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_ACC   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                 state, state_next;
  logic                   op, op_next;
  logic [WALK_W-1:0]      x, x_next, y, y_next, c0, c0_next;
  logic [COUNT_WIDTH-1:0] sum, sum_next;
  logic [ADDR_W-1:0]      clr, clr_next;

  logic [COORD_W-1:0]     side, b_cl, c_cl;
  logic [WALK_W-1:0]      x_low, y_low, x_step, y_step;
  logic                   x_end, y_end;
  logic [COUNT_WIDTH-1:0] addend, alu_out;

  ddc_alu u_alu (
    .entry  (rdata),
    .addend (addend),
    .result (alu_out)
  );

  assign addend = (op == OP_INSERT) ? COUNT_WIDTH'(1) : sum;

  always_comb begin
    if (range_in_use == '0) begin
      side = COORD_W'(1);
    end else if (range_in_use > COORD_W'(GRID_SIDE)) begin
      side = COORD_W'(GRID_SIDE);
    end else begin
      side = range_in_use;
    end
    b_cl = (coord_b > side) ? side : coord_b;
    c_cl = (coord_c > side) ? side : coord_c;
    if (opcode == OP_INSERT) begin
      if (b_cl == '0) b_cl = COORD_W'(1);
      if (c_cl == '0) c_cl = COORD_W'(1);
    end
  end

  always_comb begin
    x_low = x & (~x + WALK_W'(1));
    y_low = y & (~y + WALK_W'(1));
    if (op == OP_INSERT) begin
      x_step = x + x_low;
      y_step = y + y_low;
      x_end  = x_step > WALK_W'(GRID_SIDE);
      y_end  = y_step > WALK_W'(GRID_SIDE);
    end else begin
      x_step = x - x_low;
      y_step = y - y_low;
      x_end  = x_step == '0;
      y_end  = y_step == '0;
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    x_next      = x;
    y_next      = y;
    c0_next     = c0;
    sum_next    = sum;
    clr_next    = clr;
    in_ready    = 1'b0;
    result_load = 1'b0;
    req.we      = 1'b0;
    req.wdata   = alu_out;
    req.addr    = {IDX_W'(x - WALK_W'(1)), IDX_W'(y - WALK_W'(1))};
    unique case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.wdata = '0;
        req.addr  = clr;
        clr_next  = clr + ADDR_W'(1);
        if (clr == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next  = opcode;
          x_next   = WALK_W'(b_cl);
          y_next   = WALK_W'(c_cl);
          c0_next  = WALK_W'(c_cl);
          sum_next = '0;
          if (opcode == OP_QUERY && (coord_b == '0 || coord_c == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (op == OP_INSERT) begin
          req.we = 1'b1;
        end else begin
          sum_next = alu_out;
        end
        if (!y_end) begin
          y_next     = y_step;
          state_next = S_READ;
        end else if (!x_end) begin
          x_next     = x_step;
          y_next     = c0;
          state_next = S_READ;
        end else if (op == OP_INSERT) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign result = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    op  <= op_next;
    x   <= x_next;
    y   <= y_next;
    c0  <= c0_next;
    sum <= sum_next;
  end
endmodule
`default_nettype wire

// ===== rtl/ddc_checker.sv =====
// Port-level checks of the dominance counter, bound to the top level.
// Depends on two_dim_dominance_counter_unit_assert.svh and ddc_pkg.
`default_nettype none
`include "two_dim_dominance_counter_unit_assert.svh"
module ddc_checker import ddc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [OUT_W-1:0] dominated_count
);
  // an accepted word makes the block busy, so in_ready falls
  `DDC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")
  // stalled output word holds
  `DDC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(dominated_count), "output word changed while stalled")
  // reset empties the output register and starts the clear sweep
  `DDC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid && !in_ready, "busy output or ready after reset")
endmodule

bind two_dim_dominance_counter_unit ddc_checker u_ddc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .dominated_count (dominated_count)
);
`default_nettype wire
